FILE: rtl/core/hts_pkg.sv
// Package for the humidity and temperature sample qualifier.
// Holds the conversion constants, acceptance window, clamp limits and shared types.
// No dependencies.
package hts_pkg;

    localparam int RAW_W   = 16;
    localparam int TEMP_W  = 13;
    localparam int HUM_W   = 14;
    localparam int CORR_W  = 10;
    localparam int CNT_W   = 8;
    localparam int TC_W    = 16;
    localparam int TQ_W    = 15;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;

    localparam logic [CORR_W-1:0] CORR_RESET = 10'd200;

    localparam logic [14:0] TEMP_SCALE = 15'd17500;
    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [RAW_W:0] DIV_CONST = 17'd65535;

    localparam logic signed [TC_W-1:0] TEMP_OFFSET  = 16'sd4500;
    localparam logic signed [TC_W-1:0] TEMP_ACC_MIN = -16'sd2000;
    localparam logic signed [TC_W-1:0] TEMP_ACC_MAX = 16'sd12500;
    localparam logic signed [TC_W-1:0] TEMP_CLAMP   = 16'sd5000;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 13'd5000;
    localparam logic [HUM_W-1:0]  HUM_MAX  = 14'd9500;

    localparam logic [RAW_W-1:0] HUM_RAW_MIN = 16'h0001;
    localparam logic [RAW_W-1:0] HUM_RAW_MAX = 16'hFFFE;

    // result word layout
    localparam int O_TEMP_LSB = 0;
    localparam int O_HUM_LSB  = 13;
    localparam int O_ACC_BIT  = 27;
    localparam int O_FLT_BIT  = 28;
    localparam int O_PCR_BIT  = 29;

    typedef struct packed {
        logic signed [TC_W-1:0] temp_c;
        logic [HUM_W-1:0]       hum_c;
    } conv_t;

endpackage

FILE: rtl/core/humidity_temperature_sample_qualifier_top.sv
// Top level of the humidity and temperature sample qualifier.
// Holds the qualification state, the correction register and the result register.
// Depends on hts_pkg and hts_conv.

// One sample pair is taken per clock when ready: the conversion, window check and
// state update sit between the input handshake and a single result register, so a
// result appears in the cycle after its transaction is accepted, and the input
// stays ready while the result register is empty or being drained. The held
// temperature/humidity, fault flag and error counter update once per accepted sample.
// The user must write temp_correction via cfg_wen/cfg_wdata only while idle; the block does not check.
module humidity_temperature_sample_qualifier_top #(
    parameter int ERROR_LIMIT = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [hts_pkg::CORR_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // temp_raw[15:0], humid_raw[31:16]
    input  logic [hts_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // temperature_centi[12:0], humidity_centi[26:13], sample_accepted[27],
    // sensor_fault[28], power_cycle_request[29], zero[31:30]
    output logic [hts_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam logic [hts_pkg::CNT_W-1:0] LIMIT = hts_pkg::CNT_W'(ERROR_LIMIT);

    hts_pkg::conv_t                conv;
    logic [hts_pkg::CORR_W-1:0]    corr_reg;
    logic [hts_pkg::CNT_W-1:0]     err_cnt_reg, err_cnt_next, cnt_inc;
    logic                          fault_reg, fault_next;
    logic [hts_pkg::TEMP_W-1:0]    temp_reg, temp_next;
    logic [hts_pkg::HUM_W-1:0]     hum_reg, hum_next;
    logic                          valid_reg, valid_next;
    logic [hts_pkg::OUT_W-1:0]     data_reg, data_next;
    logic                          accept, ok, pulse;

    hts_conv u_conv (
        .temp_raw        (s_axis_tdata[15:0]),
        .humid_raw       (s_axis_tdata[31:16]),
        .temp_correction (corr_reg),
        .conv            (conv)
    );

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    always_comb begin
        ok = (conv.temp_c >= hts_pkg::TEMP_ACC_MIN) && (conv.temp_c <= hts_pkg::TEMP_ACC_MAX)
             && (s_axis_tdata[31:16] >= hts_pkg::HUM_RAW_MIN)
             && (s_axis_tdata[31:16] <= hts_pkg::HUM_RAW_MAX);
        cnt_inc      = err_cnt_reg + 8'd1;
        pulse        = 1'b0;
        temp_next    = temp_reg;
        hum_next     = hum_reg;
        err_cnt_next = err_cnt_reg;
        fault_next   = fault_reg;
        if (accept) begin
            if (ok) begin
                if (conv.temp_c[hts_pkg::TC_W-1]) begin
                    temp_next = '0;
                end else if (conv.temp_c > hts_pkg::TEMP_CLAMP) begin
                    temp_next = hts_pkg::TEMP_MAX;
                end else begin
                    temp_next = conv.temp_c[hts_pkg::TEMP_W-1:0];
                end
                hum_next     = (conv.hum_c > hts_pkg::HUM_MAX) ? hts_pkg::HUM_MAX : conv.hum_c;
                err_cnt_next = '0;
                fault_next   = 1'b0;
            end else if (cnt_inc >= LIMIT) begin
                err_cnt_next = '0;
                fault_next   = 1'b1;
                pulse        = 1'b1;
            end else begin
                err_cnt_next = cnt_inc;
            end
        end
        valid_next = accept || (valid_reg && !m_axis_tready);
        data_next  = data_reg;
        if (accept) begin
            data_next = '0;
            data_next[hts_pkg::O_TEMP_LSB +: hts_pkg::TEMP_W] = temp_next;
            data_next[hts_pkg::O_HUM_LSB +: hts_pkg::HUM_W]   = hum_next;
            data_next[hts_pkg::O_ACC_BIT] = ok;
            data_next[hts_pkg::O_FLT_BIT] = fault_next;
            data_next[hts_pkg::O_PCR_BIT] = pulse;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_reg    <= hts_pkg::CORR_RESET;
            err_cnt_reg <= '0;
            fault_reg   <= 1'b0;
            temp_reg    <= '0;
            hum_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                corr_reg <= cfg_wdata;
            end
            err_cnt_reg <= err_cnt_next;
            fault_reg   <= fault_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: rtl/core/hts_conv.sv
// Raw-to-centi conversion for temperature and humidity words.
// Scales by constants and divides by 65535 with a shift, add and single correction.
// Depends on hts_pkg.
module hts_conv (
    input  logic [hts_pkg::RAW_W-1:0]  temp_raw,
    input  logic [hts_pkg::RAW_W-1:0]  humid_raw,
    input  logic [hts_pkg::CORR_W-1:0] temp_correction,
    output hts_pkg::conv_t             conv
);

    logic [30:0]               t_prod;
    logic [29:0]               h_prod;
    logic [hts_pkg::TQ_W-1:0]  t_q0;
    logic [hts_pkg::TQ_W-1:0]  t_q;
    logic [hts_pkg::HUM_W-1:0] h_q0;
    logic [hts_pkg::HUM_W-1:0] h_q;
    logic [hts_pkg::RAW_W:0]   t_rem;
    logic [hts_pkg::RAW_W:0]   h_rem;

    // x / 65535: x = q0*65536 + lo gives remainder lo + q0, below twice the divisor
    always_comb begin
        t_prod = 31'(t_q0_dummy(temp_raw));
        h_prod = 30'(humid_raw) * 30'(hts_pkg::HUM_SCALE);
        t_q0   = t_prod[30:16];
        h_q0   = h_prod[29:16];
        t_rem  = {1'b0, t_prod[15:0]} + 17'(t_q0);
        h_rem  = {1'b0, h_prod[15:0]} + 17'(h_q0);
        t_q    = t_q0 + 15'(t_rem >= hts_pkg::DIV_CONST);
        h_q    = h_q0 + 14'(h_rem >= hts_pkg::DIV_CONST);
        conv.temp_c = $signed({1'b0, t_q}) - hts_pkg::TEMP_OFFSET
                      - $signed({6'b0, temp_correction});
        conv.hum_c  = h_q;
    end

    function automatic logic [30:0] t_q0_dummy(input logic [hts_pkg::RAW_W-1:0] raw);
        t_q0_dummy = 31'(raw) * 31'(hts_pkg::TEMP_SCALE);
    endfunction

endmodule

FILE: rtl/core/hts_checker.sv
// Port-level checker for the humidity and temperature sample qualifier.
// Bound to the top level below; depends on hts_pkg.
module hts_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [hts_pkg::OUT_W-1:0] m_axis_tdata
);

    // hold a stalled transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_pulse_sets_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[hts_pkg::O_PCR_BIT]
        |-> m_axis_tdata[hts_pkg::O_FLT_BIT] && !m_axis_tdata[hts_pkg::O_ACC_BIT])
        else $error("power-cycle request without fault");

    a_accept_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[hts_pkg::O_ACC_BIT]
        |-> !m_axis_tdata[hts_pkg::O_FLT_BIT])
        else $error("fault set on accepted sample");

    a_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
        (m_axis_tdata[hts_pkg::O_TEMP_LSB +: hts_pkg::TEMP_W] <= hts_pkg::TEMP_MAX)
        && (m_axis_tdata[hts_pkg::O_HUM_LSB +: hts_pkg::HUM_W] <= hts_pkg::HUM_MAX))
        else $error("held value outside clamp range");

endmodule

bind humidity_temperature_sample_qualifier_top hts_checker u_hts_checker (.*);

FILE: sim/humidity_temperature_sample_qualifier_top_test.sv
// Testbench for humidity_temperature_sample_qualifier_top: directed table, then random pairs.
// Each result is checked against a predictor of the block's own state, or a typed table row's result.
// Depends on hts_pkg and the RTL of the top level.
module humidity_temperature_sample_qualifier_top_test;

    import hts_pkg::*;

    localparam int ERROR_LIMIT  = 10;
    localparam int RAW_FULL     = 65535;
    localparam int PHASE_ITEMS  = 225;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic              acc;
        logic              flt;
        logic              pcr;
    } reading_t;

    typedef struct {
        logic [RAW_W-1:0]  t_raw;
        logic [RAW_W-1:0]  h_raw;
        bit                typed;
        reading_t          res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wen;
    logic [CORR_W-1:0]   cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    // predictor state
    logic [CORR_W-1:0]   correction;
    logic [CNT_W-1:0]    err_cnt;
    logic                fault;
    logic [TEMP_W-1:0]   held_temp;
    logic [HUM_W-1:0]    held_hum;

    reading_t            pending_readings[$];
    int                  mismatch_count = 0;
    int                  tx_idle_pct;
    int                  rx_idle_pct;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{16'h0000, 16'h0000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'hFFFF, 16'hFFFF, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'hFFFF, 16'h8000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'h8000, 16'h0000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'h8000, 16'hFFFF, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'h0000, 16'h8000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'h0000, 16'h0001, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'hFFFF, 16'h0001, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'h1234, 16'h0000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b0, 1'b0}},
        '{16'hFFFF, 16'h0000, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b1, 1'b1}},
        '{16'h0000, 16'hFFFF, 1'b1, '{13'd0, 14'd0, 1'b0, 1'b1, 1'b0}},
        '{16'h8000, 16'h0001, 1'b0, '0},
        '{16'h8000, 16'hFFFE, 1'b0, '0},
        '{16'd10111, 16'd4000, 1'b0, '0},
        '{16'd10112, 16'd4000, 1'b0, '0},
        '{16'd17601, 16'd12345, 1'b0, '0},
        '{16'd36326, 16'd62258, 1'b0, '0},
        '{16'd36330, 16'd62259, 1'b0, '0},
        '{16'd64412, 16'd30000, 1'b0, '0},
        '{16'd64416, 16'd30000, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, '0}
    };

    humidity_temperature_sample_qualifier_top #(
        .ERROR_LIMIT(ERROR_LIMIT)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic reading_t qualify_pair(input logic [RAW_W-1:0] t_raw,
                                              input logic [RAW_W-1:0] h_raw);
        int       scaled;
        int       t_c;
        int       h_c;
        bit       ok;
        reading_t r;
        scaled = (int'(TEMP_SCALE) * int'(t_raw)) / RAW_FULL;
        t_c    = scaled - int'(TEMP_OFFSET) - int'(correction);
        h_c    = (int'(HUM_SCALE) * int'(h_raw)) / RAW_FULL;
        ok     = (t_c >= int'(TEMP_ACC_MIN)) && (t_c <= int'(TEMP_ACC_MAX)) &&
                 (h_raw >= HUM_RAW_MIN) && (h_raw <= HUM_RAW_MAX);
        r.pcr  = 1'b0;
        if (ok) begin
            if (t_c < 0)
                held_temp = '0;
            else if (t_c > int'(TEMP_MAX))
                held_temp = TEMP_MAX;
            else
                held_temp = TEMP_W'(t_c);
            held_hum = (h_c > int'(HUM_MAX)) ? HUM_MAX : HUM_W'(h_c);
            err_cnt  = '0;
            fault    = 1'b0;
        end else begin
            err_cnt = err_cnt + 1'b1;
            if (int'(err_cnt) >= ERROR_LIMIT) begin
                fault   = 1'b1;
                r.pcr   = 1'b1;
                err_cnt = '0;
            end
        end
        r.temp = held_temp;
        r.hum  = held_hum;
        r.acc  = ok;
        r.flt  = fault;
        return r;
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_pair(input logic [RAW_W-1:0] t_raw, input logic [RAW_W-1:0] h_raw,
                             input bit typed, input reading_t typed_res);
        reading_t r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h_raw, t_raw};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        r = qualify_pair(t_raw, h_raw);
        pending_readings.push_back(typed ? typed_res : r);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_correction(input logic [CORR_W-1:0] value);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen    <= 1'b0;
        correction = value;
        @(negedge aclk);
    endtask

    task automatic send_random(input int kind);
        logic [RAW_W-1:0] t_raw;
        logic [RAW_W-1:0] h_raw;
        t_raw = 16'($urandom_range(16000, 63000));
        h_raw = 16'($urandom_range(1, 65534));
        if (kind == 1) begin
            case ($urandom_range(0, 3))
                0: t_raw = 16'($urandom_range(0, 8000));
                1: h_raw = 16'h0000;
                2: h_raw = 16'hFFFF;
                default: t_raw = 16'($urandom_range(65200, 65535));
            endcase
        end else if (kind == 2) begin
            t_raw = 16'($urandom_range(0, 65535));
            h_raw = 16'($urandom_range(0, 65535));
        end
        send_pair(t_raw, h_raw, 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch_results
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected transaction: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("temperature_centi", want.temp,
                            m_axis_tdata[O_TEMP_LSB +: TEMP_W]);
                check_field("humidity_centi", want.hum, m_axis_tdata[O_HUM_LSB +: HUM_W]);
                check_field("sample_accepted", want.acc, m_axis_tdata[O_ACC_BIT]);
                check_field("sensor_fault", want.flt, m_axis_tdata[O_FLT_BIT]);
                check_field("power_cycle_request", want.pcr, m_axis_tdata[O_PCR_BIT]);
            end
        end
    end

    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    initial begin
        #3000000;
        $display("humidity_temperature_sample_qualifier_top verification failed");
        $finish;
    end

    initial begin
        int left;
        int run;
        int kind;
        int guard;
        logic [CORR_W-1:0] corr;
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 29;
        rx_idle_pct   = 50;
        correction    = CORR_RESET;
        err_cnt       = '0;
        fault         = 1'b0;
        held_temp     = '0;
        held_hum      = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_pair(dir_rows[i].t_raw, dir_rows[i].h_raw, dir_rows[i].typed, dir_rows[i].res);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 50;
                end
                1: begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (phase)
                0: corr = 10'd1023;
                1: corr = 10'd0;
                2: corr = 10'd500;
                3: corr = 10'd1000;
                default: corr = CORR_W'($urandom_range(0, 1023));
            endcase
            write_correction(corr);
            left = PHASE_ITEMS;
            while (left > 0) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    kind = 1;
                    run  = $urandom_range(1, 13);
                end else if (kind < 90) begin
                    kind = 0;
                    run  = $urandom_range(1, 8);
                end else begin
                    kind = 2;
                    run  = $urandom_range(1, 4);
                end
                for (int k = 0; k < run && left > 0; k++) begin
                    send_random(kind);
                    left--;
                end
                if ($urandom_range(0, 99) < 3)
                    drain_results();
            end
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_readings.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $error("%0d expected transactions never arrived", pending_readings.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("humidity_temperature_sample_qualifier_top verification clean");
        end else begin
            $display("humidity_temperature_sample_qualifier_top verification failed");
        end
        $finish;
    end

endmodule
